// ===== src/lcdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdsr_pkg
// Shared types and constants for the LCD shift register write sequencer.
// ----------------------------------------------------------------------------
package lcdsr_pkg;

    // Text filter constants.
    localparam logic [7:0]  TEXT_LOW      = 8'h20;
    localparam logic [7:0]  TEXT_HIGH     = 8'h7D;
    localparam logic [2:0]  LEAD_PREFIX   = 3'h6;
    localparam logic [15:0] DEGREE_PAIR   = 16'hC2B0;

    // Configuration defaults.
    localparam logic [7:0]  DEGREE_GLYPH_RESET   = 8'd223;
    localparam logic [9:0]  COMMAND_SETTLE_RESET = 10'd700;
    localparam logic [9:0]  DATA_SETTLE_RESET    = 10'd50;

    // Hold times of the fixed snapshots, microseconds.
    localparam logic [9:0]  HOLD_NONE  = 10'd0;
    localparam logic [9:0]  HOLD_STEP  = 10'd1;
    localparam logic [9:0]  HOLD_LATCH = 10'd10;
    localparam logic [9:0]  HOLD_EN    = 10'd40;

    // Write queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_DEGREE_GLYPH   = 2'd0,
        CFG_COMMAND_SETTLE = 2'd1,
        CFG_DATA_SETTLE    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] degree_glyph;
        logic [9:0] command_settle_us;
        logic [9:0] data_settle_us;
    } t_cfg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_request;

    typedef struct packed {
        logic       sr_data;
        logic       sr_clock;
        logic       sr_latch;
        logic       sr_clear_n;
        logic       lcd_rs;
        logic       lcd_enable;
        logic [9:0] hold_us;
        logic       last;
    } t_result;

    // One LCD write handed from the front to the back.
    typedef struct packed {
        logic       is_data;
        logic [7:0] wr_byte;
    } t_write;

    typedef struct packed {
        logic en;
        logic rs;
        logic clear_n;
        logic latch;
        logic clock;
        logic data;
    } t_pins;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR_LO,
        S_LAT_HI,
        S_LAT_LO,
        S_CLR_HI,
        S_RS,
        S_DATA,
        S_CLK_HI,
        S_CLK_LO,
        S_LAT2_HI,
        S_LAT2_LO,
        S_EN_HI,
        S_EN_LO
    } t_seq_state;

endpackage

// ===== src/lcdsr_front.sv =====
// ----------------------------------------------------------------------------
// lcdsr_front
// Classifies requests: commands pass as they are, text goes through the
// UTF-8 filter that keeps one pending lead byte.
// ----------------------------------------------------------------------------
module lcdsr_front
    import lcdsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_request i_req,
    input  t_cfg     i_cfg,
    output logic     o_wr_valid,
    output t_write   o_wr
);

    logic [7:0] r_lead_byte;
    logic       r_lead_pending;
    logic [7:0] n_lead_byte;
    logic       n_lead_pending;

    always_comb begin
        n_lead_byte    = r_lead_byte;
        n_lead_pending = r_lead_pending;
        o_wr_valid     = 1'b0;
        o_wr.is_data   = 1'b1;
        o_wr.wr_byte   = i_req.data_byte;
        if (i_req.action) begin
            // A command leaves any pending lead byte in place.
            o_wr_valid   = 1'b1;
            o_wr.is_data = 1'b0;
        end else if (r_lead_pending) begin
            n_lead_pending = 1'b0;
            if ({r_lead_byte, i_req.data_byte} == DEGREE_PAIR) begin
                o_wr_valid   = 1'b1;
                o_wr.wr_byte = i_cfg.degree_glyph;
            end
        end else if (!i_req.data_byte[7]) begin
            o_wr_valid = (i_req.data_byte >= TEXT_LOW) && (i_req.data_byte <= TEXT_HIGH);
        end else if (i_req.data_byte[7:5] == LEAD_PREFIX) begin
            n_lead_byte    = i_req.data_byte;
            n_lead_pending = 1'b1;
        end
        if (!i_accept) begin
            o_wr_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_byte    <= 8'd0;
            r_lead_pending <= 1'b0;
        end else if (i_accept) begin
            r_lead_byte    <= n_lead_byte;
            r_lead_pending <= n_lead_pending;
        end
    end

endmodule

// ===== src/lcdsr_queue.sv =====
// ----------------------------------------------------------------------------
// lcdsr_queue
// Short queue of pending LCD writes between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module lcdsr_queue
    import lcdsr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_write i_wr,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_write o_wr
);

    t_write               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_wr    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/lcdsr_back.sv =====
// ----------------------------------------------------------------------------
// lcdsr_back
// Pin sequencer: turns one queued write into 33 pin snapshots, one per cycle
// while the result side pops, through a single output register.
// ----------------------------------------------------------------------------
module lcdsr_back
    import lcdsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_empty,
    input  t_write  i_q_wr,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    t_seq_state r_state;
    t_seq_state n_state;
    logic [2:0] r_bit;
    logic [2:0] n_bit;
    t_write     r_cmd;
    t_write     n_cmd;
    t_pins      r_pins;
    t_pins      n_pins;
    t_result    r_out;
    logic       r_out_valid;
    logic       advance;
    logic [9:0] hold;
    logic       last;

    assign advance = !r_out_valid || i_pop;
    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= 3'd0;
            r_pins  <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_pins  <= n_pins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_cmd   = r_cmd;
        n_pins  = r_pins;
        hold    = HOLD_NONE;
        last    = 1'b0;
        o_q_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_wr;
                    n_state = S_CLR_LO;
                end
            end
            S_CLR_LO: begin
                n_pins.clear_n = 1'b0;
                hold           = HOLD_STEP;
                n_state        = S_LAT_HI;
            end
            S_LAT_HI: begin
                n_pins.latch = 1'b1;
                hold         = HOLD_STEP;
                n_state      = S_LAT_LO;
            end
            S_LAT_LO: begin
                n_pins.latch = 1'b0;
                n_state      = S_CLR_HI;
            end
            S_CLR_HI: begin
                n_pins.clear_n = 1'b1;
                hold           = HOLD_STEP;
                n_state        = S_RS;
            end
            S_RS: begin
                n_pins.rs = r_cmd.is_data;
                hold      = HOLD_STEP;
                n_bit     = 3'd7;
                n_state   = S_DATA;
            end
            S_DATA: begin
                n_pins.data = r_cmd.wr_byte[r_bit];
                n_state     = S_CLK_HI;
            end
            S_CLK_HI: begin
                n_pins.clock = 1'b1;
                n_state      = S_CLK_LO;
            end
            S_CLK_LO: begin
                n_pins.clock = 1'b0;
                if (r_bit == 3'd0) begin
                    n_state = S_LAT2_HI;
                end else begin
                    n_bit   = r_bit - 3'd1;
                    n_state = S_DATA;
                end
            end
            S_LAT2_HI: begin
                n_pins.latch = 1'b1;
                hold         = HOLD_LATCH;
                n_state      = S_LAT2_LO;
            end
            S_LAT2_LO: begin
                n_pins.latch = 1'b0;
                n_state      = S_EN_HI;
            end
            S_EN_HI: begin
                n_pins.en = 1'b1;
                hold      = HOLD_EN;
                n_state   = S_EN_LO;
            end
            S_EN_LO: begin
                n_pins.en = 1'b0;
                hold      = r_cmd.is_data ? i_cfg.data_settle_us : i_cfg.command_settle_us;
                last      = 1'b1;
                // Chain straight into the next queued write without returning to idle.
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_wr;
                    n_state = S_CLR_LO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A snapshot that cannot be placed in the output register waits.
        if (!advance && r_state != S_IDLE) begin
            n_state = r_state;
            n_bit   = r_bit;
            n_cmd   = r_cmd;
            n_pins  = r_pins;
            o_q_pop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= (r_state != S_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.sr_data    <= n_pins.data;
            r_out.sr_clock   <= n_pins.clock;
            r_out.sr_latch   <= n_pins.latch;
            r_out.sr_clear_n <= n_pins.clear_n;
            r_out.lcd_rs     <= n_pins.rs;
            r_out.lcd_enable <= n_pins.en;
            r_out.hold_us    <= hold;
            r_out.last       <= last;
        end
    end

`ifndef SYNTH
    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("write taken from an empty queue");

    a_pop_starts_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == S_CLR_LO)
        else $error("queued write did not start a pin sequence");

    a_last_bit_latches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLK_LO && advance && r_bit == 3'd0) |=> r_state == S_LAT2_HI)
        else $error("shift did not end after the least significant bit");

    a_last_pins_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |->
            (!r_out.sr_clock && !r_out.sr_latch && !r_out.lcd_enable && r_out.sr_clear_n))
        else $error("final snapshot of a write left a strobe active");
`endif

endmodule

// ===== src/lcd_shift_register_write_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// lcd_shift_register_write_sequencer_core
// Requests (text or command bytes) are accepted one per cycle while full is
// low. Text that the UTF-8 filter drops, or a held lead byte, produces
// nothing. Every byte that is written to the LCD produces 33 pin snapshots,
// one per cycle while pop keeps the result side drained, as the pin
// sequencer steps through its states. Up to two classified writes wait in
// the queue between the filter and the sequencer; full rises when that
// queue is full. Configuration registers reset to degree glyph 223, command
// settle 700 us and data settle 50 us; the user must write them only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module lcd_shift_register_write_sequencer_core
    import lcdsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  t_request   i_req,
    output logic       full,
    output logic       empty,
    input  logic       pop,
    output t_result    o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   accept;
    logic   wr_valid;
    t_write wr;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    t_write q_wr;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.degree_glyph      <= DEGREE_GLYPH_RESET;
            r_cfg.command_settle_us <= COMMAND_SETTLE_RESET;
            r_cfg.data_settle_us    <= DATA_SETTLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEGREE_GLYPH:   r_cfg.degree_glyph      <= i_cfg_data[7:0];
                CFG_COMMAND_SETTLE: r_cfg.command_settle_us <= i_cfg_data;
                CFG_DATA_SETTLE:    r_cfg.data_settle_us    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lcdsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (i_req),
        .i_cfg      (r_cfg),
        .o_wr_valid (wr_valid),
        .o_wr       (wr)
    );

    lcdsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wr_valid),
        .i_wr    (wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_wr    (q_wr)
    );

    lcdsr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_wr    (q_wr),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (o_res)
    );

endmodule

// ===== verif/lcd_shift_register_write_sequencer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD shift register write sequencer testbench
// Drives text and command requests through the queue-style input port and
// checks every pin snapshot against a cycle-free predictor of the UTF-8
// filter and the shift register write sequence. The run goes through the
// reset register values, both extremes and random settings, with random
// idling on both sides, a long result-side hold-off and an idle-free phase.
// ----------------------------------------------------------------------------
module lcd_shift_register_write_sequencer_core_test;
    import lcdsr_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int CLK_PERIOD      = 2 * HALF_PERIOD;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int IDLE_PERCENT    = 32;
    localparam int PHASE_REQUESTS  = 30;

    localparam logic       ACTION_TEXT      = 1'b0;
    localparam logic       ACTION_COMMAND   = 1'b1;
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    t_request   i_req       = '0;
    logic       full;
    logic       empty;
    logic       pop         = 1'b0;
    t_result    o_res;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [9:0] i_cfg_data  = '0;

    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit hold_off_req = 1'b0;
    int settings_run = 0;

    class lcd_pin_scoreboard;
        t_cfg    cfg;
        t_pins   pins;
        logic [7:0] lead_byte;
        logic    lead_held;
        t_result expected_snapshots[$];
        int      errors;
        int      requests_seen;
        int      writes_predicted;
        int      snapshots_checked;

        function new();
            cfg.degree_glyph      = DEGREE_GLYPH_RESET;
            cfg.command_settle_us = COMMAND_SETTLE_RESET;
            cfg.data_settle_us    = DATA_SETTLE_RESET;
            pins              = '0;
            lead_byte         = '0;
            lead_held         = 1'b0;
            errors            = 0;
            requests_seen     = 0;
            writes_predicted  = 0;
            snapshots_checked = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [9:0] value);
            case (index)
                CFG_DEGREE_GLYPH:   cfg.degree_glyph      = value[7:0];
                CFG_COMMAND_SETTLE: cfg.command_settle_us = value;
                CFG_DATA_SETTLE:    cfg.data_settle_us    = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_snapshots.size();
        endfunction

        function void snapshot(logic [9:0] hold, logic is_last);
            t_result r;
            r.sr_data    = pins.data;
            r.sr_clock   = pins.clock;
            r.sr_latch   = pins.latch;
            r.sr_clear_n = pins.clear_n;
            r.lcd_rs     = pins.rs;
            r.lcd_enable = pins.en;
            r.hold_us    = hold;
            r.last       = is_last;
            expected_snapshots.push_back(r);
        endfunction

        // One LCD write: clear the register, set RS, shift MSB first,
        // latch, then strobe enable.
        function void predict_lcd_write(logic [7:0] value, logic is_data);
            writes_predicted++;
            pins.clear_n = 1'b0; snapshot(HOLD_STEP, 1'b0);
            pins.latch   = 1'b1; snapshot(HOLD_STEP, 1'b0);
            pins.latch   = 1'b0; snapshot(HOLD_NONE, 1'b0);
            pins.clear_n = 1'b1; snapshot(HOLD_STEP, 1'b0);
            pins.rs      = is_data; snapshot(HOLD_STEP, 1'b0);
            for (int k = 7; k >= 0; k--) begin
                pins.data  = value[k]; snapshot(HOLD_NONE, 1'b0);
                pins.clock = 1'b1;     snapshot(HOLD_NONE, 1'b0);
                pins.clock = 1'b0;     snapshot(HOLD_NONE, 1'b0);
            end
            pins.latch = 1'b1; snapshot(HOLD_LATCH, 1'b0);
            pins.latch = 1'b0; snapshot(HOLD_NONE, 1'b0);
            pins.en    = 1'b1; snapshot(HOLD_EN, 1'b0);
            pins.en    = 1'b0;
            snapshot(is_data ? cfg.data_settle_us : cfg.command_settle_us, 1'b1);
        endfunction

        function void note_request(t_request r);
            requests_seen++;
            if (r.action == ACTION_COMMAND) begin
                // A command leaves a held lead byte untouched.
                predict_lcd_write(r.data_byte, 1'b0);
            end else if (lead_held) begin
                lead_held = 1'b0;
                if ({lead_byte, r.data_byte} == DEGREE_PAIR)
                    predict_lcd_write(cfg.degree_glyph, 1'b1);
            end else if (r.data_byte[7] == 1'b0) begin
                if (r.data_byte >= TEXT_LOW && r.data_byte <= TEXT_HIGH)
                    predict_lcd_write(r.data_byte, 1'b1);
            end else if (r.data_byte[7:5] == LEAD_PREFIX) begin
                lead_byte = r.data_byte;
                lead_held = 1'b1;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_snapshots.size() == 0) begin
                $error("pin snapshot with no request behind it: %h", got);
                errors++;
            end else begin
                want = expected_snapshots.pop_front();
                snapshots_checked++;
                compare_field("sr_data",    want.sr_data,    got.sr_data);
                compare_field("sr_clock",   want.sr_clock,   got.sr_clock);
                compare_field("sr_latch",   want.sr_latch,   got.sr_latch);
                compare_field("sr_clear_n", want.sr_clear_n, got.sr_clear_n);
                compare_field("lcd_rs",     want.lcd_rs,     got.lcd_rs);
                compare_field("lcd_enable", want.lcd_enable, got.lcd_enable);
                compare_field("hold_us",    want.hold_us,    got.hold_us);
                compare_field("last",       want.last,       got.last);
            end
        endfunction
    endclass

    lcd_pin_scoreboard sb = new();

    lcd_shift_register_write_sequencer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_req       (i_req),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                sb.note_request(i_req);
            if (pop && !empty)
                sb.check_result(o_res);
        end
    end

    // Result side: random idling, an idle-free phase and one long hold-off.
    initial begin : result_drain
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_used) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (rx_steady) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic send_request(input logic action, input logic [7:0] value);
        t_request r;
        r.action    = action;
        r.data_byte = value;
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_register(input logic [1:0] index, input logic [9:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        sb.set_register(index, value);
        @(posedge i_clk);
    endtask

    // The glyph write carries random upper bits, which the register drops.
    task automatic configure(input logic [7:0] glyph, input logic [9:0] cmd_settle,
                             input logic [9:0] data_settle);
        write_register(CFG_DEGREE_GLYPH, {2'($urandom), glyph});
        write_register(CFG_COMMAND_SETTLE, cmd_settle);
        write_register(CFG_DATA_SETTLE, data_settle);
        write_register(CFG_UNUSED_INDEX, 10'($urandom));
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Filtered requests leave no result, so the drain keeps waiting after the
    // last expected snapshot before the block counts as idle. Push is dropped
    // and the last accepted request is noted before the pending check begins.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_request(ACTION_TEXT, TEXT_LOW);
        send_request(ACTION_TEXT, TEXT_HIGH);
        send_request(ACTION_TEXT, 8'h7E);
        send_request(ACTION_TEXT, 8'h1F);
        send_request(ACTION_TEXT, 8'h00);
        send_request(ACTION_TEXT, 8'hFF);
        send_request(ACTION_TEXT, 8'h80);
        send_request(ACTION_COMMAND, 8'h00);
        send_request(ACTION_COMMAND, 8'hFF);
        send_request(ACTION_TEXT, DEGREE_PAIR[15:8]);
        send_request(ACTION_TEXT, DEGREE_PAIR[7:0]);
        send_request(ACTION_TEXT, 8'hC3);
        send_request(ACTION_TEXT, 8'hA9);
        // A command between the two halves of the degree sign.
        send_request(ACTION_TEXT, DEGREE_PAIR[15:8]);
        send_request(ACTION_COMMAND, 8'h80);
        send_request(ACTION_TEXT, DEGREE_PAIR[7:0]);
        // A second lead byte is eaten as the pair byte, not held.
        send_request(ACTION_TEXT, 8'hC2);
        send_request(ACTION_TEXT, 8'hC2);
        send_request(ACTION_TEXT, 8'h41);
        send_request(ACTION_TEXT, 8'hDF);
        send_request(ACTION_TEXT, 8'h41);
        send_request(ACTION_TEXT, 8'hE2);
        send_request(ACTION_TEXT, 8'hB0);
        send_request(ACTION_TEXT, 8'hC0);
        send_request(ACTION_TEXT, 8'hB0);
    endtask

    // Mostly well-formed text, commands and UTF-8 pairs; the rest is noise,
    // which does not count toward the phase length.
    task automatic run_random(input int count);
        int done;
        int pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_request(ACTION_TEXT, 8'($urandom_range(TEXT_LOW, TEXT_HIGH)));
                done++;
            end else if (pick < 60) begin
                send_request(ACTION_COMMAND, 8'($urandom));
                done++;
            end else if (pick < 75) begin
                send_request(ACTION_TEXT, DEGREE_PAIR[15:8]);
                if ($urandom_range(3) == 0)
                    send_request(ACTION_COMMAND, 8'($urandom));
                send_request(ACTION_TEXT, DEGREE_PAIR[7:0]);
                done++;
            end else if (pick < 85) begin
                send_request(ACTION_TEXT, {LEAD_PREFIX, 5'($urandom)});
                send_request(ACTION_TEXT, 8'($urandom));
                done++;
            end else begin
                send_request(1'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain();

        configure(8'h00, 10'd0, 10'd0);
        run_random(PHASE_REQUESTS);
        drain();

        configure(8'hFF, 10'h3FF, 10'h3FF);
        hold_off_req <= 1'b1;
        run_random(PHASE_REQUESTS);
        drain();

        configure(8'($urandom), 10'($urandom), 10'($urandom));
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        run_random(PHASE_REQUESTS);
        drain();

        configure(8'($urandom), 10'($urandom), 10'($urandom));
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
        run_random(PHASE_REQUESTS);
        drain();

        $display("Covered %0d requests and %0d LCD writes over %0d register settings.",
                 sb.requests_seen, sb.writes_predicted, settings_run + 1);
        $display("Checked %0d pin snapshots, %0d mismatches.",
                 sb.snapshots_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("lcd_shift_register_write_sequencer_core verification clean");
        end else begin
            $display("lcd_shift_register_write_sequencer_core verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d pin snapshots outstanding.", sb.pending());
        $display("lcd_shift_register_write_sequencer_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lcdsr_pkg.sv
src/lcdsr_front.sv
src/lcdsr_queue.sv
src/lcdsr_back.sv
src/lcd_shift_register_write_sequencer_core.sv
verif/lcd_shift_register_write_sequencer_core_test.sv
